[sv/rmie_pkg.sv]
// Shared types and constants of the rendezvous message engine.
package rmie_pkg;

	localparam int PROC_COUNT_DEF = 16;
	localparam logic [7:0] NOTIFY_TYPE = 8'hFF;
	localparam logic [63:0] NOTIFY_PAYLOAD = 64'd2;

	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_RECV    = 2'd1,
		CMD_SENDREC = 2'd2,
		CMD_NOTIFY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_DONE     = 3'd0,
		KIND_REJECT   = 3'd1,
		KIND_BLOCKED  = 3'd2,
		KIND_DELIVER  = 3'd3,
		KIND_RELEASED = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_DONE,
		ST_A_RD,
		ST_A_CHK,
		ST_BLK,
		ST_BLK_R,
		ST_T_RD,
		ST_T_CHK,
		ST_T_HIT,
		ST_T_REL
	} state_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [2:0]  kind;
		logic [4:0]  msg_from;
		logic [7:0]  msg_out_type;
		logic [63:0] msg_out_payload;
		logic        runnable;
		logic        last;
	} res_t;

endpackage

[sv/rmie_if.sv]
// Request and result channel interfaces of the rendezvous message engine.
interface rmie_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  caller;
	logic [4:0]  peer;
	logic [7:0]  msg_type;
	logic [63:0] msg_payload;

	modport source(output valid, cmd, caller, peer, msg_type, msg_payload, input ready);
	modport sink(input valid, cmd, caller, peer, msg_type, msg_payload, output ready);
endinterface

interface rmie_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  target;
	logic [2:0]  kind;
	logic [4:0]  msg_from;
	logic [7:0]  msg_out_type;
	logic [63:0] msg_out_payload;
	logic        runnable;
	logic        last;

	modport source(output valid, target, kind, msg_from, msg_out_type, msg_out_payload,
		runnable, last, input ready);
	modport sink(input valid, target, kind, msg_from, msg_out_type, msg_out_payload,
		runnable, last, output ready);
endinterface

[sv/rmie_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module rmie_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[sv/rendezvous_message_ipc_engine.sv]
// Rendezvous message engine: one command at a time, state in flags, heads and two RAMs.
// Notify, rejects and direct sends need no list walk; a queued send or a receive walks
// the sender list in the link RAM node by node, through a read state and a check state.
// One command at a time: take the next request once the final result
// of the current one is loaded into the output register.
// Reset: flags cleared and all list heads empty; message and link RAMs are not cleared.
// Link and message RAM entries are always written before they are read.
module rendezvous_message_ipc_engine #(
	parameter int PROC_COUNT = rmie_pkg::PROC_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rmie_req_if.sink   req,
	rmie_res_if.source res
);
	import rmie_pkg::*;

	localparam int IW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
	localparam int LW = $clog2(PROC_COUNT + 1);
	localparam logic [LW-1:0] NO_PROC = LW'(PROC_COUNT);
	localparam logic [4:0] ANY_FROM = 5'(PROC_COUNT);

	state_t state_q, state_d;

	cmd_t        cmd_q;
	logic [3:0]  c_q;
	logic [4:0]  peer_q;
	logic [7:0]  type_q;
	logic [63:0] pay_q;
	logic [LW-1:0] want_q, ptr_q, prev_q;

	logic [PROC_COUNT-1:0] send_q, recv_q, pend_q;
	logic [LW-1:0] ws_q   [PROC_COUNT];
	logic [LW-1:0] head_q [PROC_COUNT];

	logic ov_q;
	res_t od_q, res_d;
	logic fire, can_emit;

	logic          nx_we, nx_re;
	logic [IW-1:0] nx_waddr, nx_raddr;
	logic [LW-1:0] nx_wdata, nx_rdata;
	logic          mg_we, mg_re;
	logic [IW-1:0] mg_raddr;
	logic [71:0]   mg_rdata;

	logic [IW-1:0] c_idx, p_idx, ptr_idx, h_idx;
	logic c_bad, p_bad, p_any, c_free, bad_peer, direct_ok, match, is_reject;
	logic [LW-1:0] hd;

	assign c_idx   = IW'(c_q);
	assign p_idx   = IW'(peer_q);
	assign ptr_idx = IW'(ptr_q);
	assign c_bad   = int'(c_q) >= PROC_COUNT;
	assign p_bad   = int'(peer_q) >= PROC_COUNT;
	assign p_any   = int'(peer_q) == PROC_COUNT;
	assign c_free  = !c_bad && !send_q[c_idx] && !recv_q[c_idx];
	assign bad_peer = (cmd_q == CMD_RECV) ? (p_bad && !p_any) : p_bad;
	assign direct_ok = !p_bad && recv_q[p_idx]
		&& (ws_q[p_idx] == NO_PROC || ws_q[p_idx] == LW'(c_q));
	assign is_reject = !c_free || bad_peer;
	// one head read port: caller list for receive and after a hand-off, else peer list
	assign h_idx = (cmd_q == CMD_RECV || direct_ok) ? c_idx : p_idx;
	assign hd    = head_q[h_idx];
	assign match = (want_q == NO_PROC) || (want_q == ptr_q);
	assign can_emit = !ov_q || res.ready;
	assign req.ready = (state_q == ST_IDLE);

	rmie_ram #(.DEPTH(PROC_COUNT), .WIDTH(LW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(nx_re), .raddr(nx_raddr), .rdata(nx_rdata)
	);

	rmie_ram #(.DEPTH(PROC_COUNT), .WIDTH(72)) u_msg (
		.clk(clk), .we(mg_we), .waddr(c_idx), .wdata({type_q, pay_q}),
		.re(mg_re), .raddr(mg_raddr), .rdata(mg_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_DEC;
			end
			ST_DEC: begin
				priority if (cmd_q == CMD_NOTIFY || is_reject) begin
					if (can_emit) state_d = ST_IDLE;
				end else if (cmd_q == CMD_RECV) begin
					if (pend_q[c_idx]) begin
						if (can_emit) state_d = ST_IDLE;
					end else begin
						state_d = (hd == NO_PROC) ? ST_BLK_R : ST_T_RD;
					end
				end else if (direct_ok) begin
					if (can_emit) begin
						if (cmd_q == CMD_SEND) state_d = ST_DONE;
						else state_d = (hd == NO_PROC) ? ST_BLK_R : ST_T_RD;
					end
				end else begin
					state_d = (hd == NO_PROC) ? ST_BLK : ST_A_RD;
				end
			end
			ST_A_RD: state_d = ST_A_CHK;
			ST_A_CHK: state_d = (nx_rdata == NO_PROC) ? ST_BLK : ST_A_RD;
			ST_T_RD: state_d = ST_T_CHK;
			ST_T_CHK: begin
				priority if (match) state_d = ST_T_HIT;
				else if (nx_rdata == NO_PROC) state_d = ST_BLK_R;
				else state_d = ST_T_RD;
			end
			ST_T_HIT: begin
				if (can_emit) state_d = ST_T_REL;
			end
			ST_DONE, ST_BLK, ST_BLK_R, ST_T_REL: begin
				if (can_emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// results and RAM controls
	always_comb begin
		fire = 1'b0;
		res_d = '0;
		nx_we = 1'b0;
		nx_waddr = ptr_idx;
		nx_wdata = NO_PROC;
		nx_re = 1'b0;
		nx_raddr = ptr_idx;
		mg_we = 1'b0;
		mg_re = 1'b0;
		mg_raddr = ptr_idx;
		unique case (state_q)
			ST_DEC: begin
				res_d.last = 1'b1;
				priority if (cmd_q == CMD_NOTIFY) begin
					fire = can_emit;
					if (p_bad) begin
						res_d.kind = KIND_REJECT;
					end else begin
						res_d.target = 4'(peer_q);
						res_d.runnable = !send_q[p_idx];
						if (recv_q[p_idx]) begin
							res_d.kind = KIND_DELIVER;
							res_d.msg_from = ANY_FROM;
							res_d.msg_out_type = NOTIFY_TYPE;
							res_d.msg_out_payload = NOTIFY_PAYLOAD;
						end else begin
							res_d.kind = KIND_DONE;
						end
					end
				end else if (is_reject) begin
					fire = can_emit;
					res_d.target = c_q;
					res_d.kind = KIND_REJECT;
					res_d.runnable = c_free;
				end else if (cmd_q == CMD_RECV) begin
					if (pend_q[c_idx]) begin
						fire = can_emit;
						res_d.target = c_q;
						res_d.kind = KIND_DELIVER;
						res_d.msg_from = ANY_FROM;
						res_d.msg_out_type = NOTIFY_TYPE;
						res_d.msg_out_payload = NOTIFY_PAYLOAD;
						res_d.runnable = 1'b1;
					end
				end else if (direct_ok) begin
					fire = can_emit;
					res_d.target = 4'(peer_q);
					res_d.kind = KIND_DELIVER;
					res_d.msg_from = 5'(c_q);
					res_d.msg_out_type = type_q;
					res_d.msg_out_payload = pay_q;
					res_d.runnable = !send_q[p_idx];
					res_d.last = 1'b0;
				end else begin
					// hold the message and terminate the caller's own link
					mg_we = 1'b1;
					nx_we = 1'b1;
					nx_waddr = c_idx;
				end
			end
			ST_DONE: begin
				fire = can_emit;
				res_d.target = c_q;
				res_d.kind = KIND_DONE;
				res_d.runnable = 1'b1;
				res_d.last = 1'b1;
			end
			ST_BLK, ST_BLK_R: begin
				fire = can_emit;
				res_d.target = c_q;
				res_d.kind = KIND_BLOCKED;
				res_d.last = 1'b1;
			end
			ST_A_RD, ST_T_RD: nx_re = 1'b1;
			ST_A_CHK: begin
				if (nx_rdata == NO_PROC) begin
					nx_we = 1'b1;
					nx_wdata = LW'(c_q);
				end
			end
			ST_T_CHK: begin
				if (match) begin
					mg_re = 1'b1;
					if (prev_q != NO_PROC) begin
						nx_we = 1'b1;
						nx_waddr = IW'(prev_q);
						nx_wdata = nx_rdata;
					end
				end
			end
			ST_T_HIT: begin
				nx_we = 1'b1;
				fire = can_emit;
				res_d.target = c_q;
				res_d.kind = KIND_DELIVER;
				res_d.msg_from = 5'(ptr_q);
				res_d.msg_out_type = mg_rdata[71:64];
				res_d.msg_out_payload = mg_rdata[63:0];
				res_d.runnable = 1'b1;
			end
			ST_T_REL: begin
				fire = can_emit;
				res_d.target = 4'(ptr_q);
				res_d.kind = KIND_RELEASED;
				res_d.runnable = !recv_q[ptr_idx];
				res_d.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			send_q <= '0;
			recv_q <= '0;
			pend_q <= '0;
			for (int i = 0; i < PROC_COUNT; i++) begin
				head_q[i] <= NO_PROC;
			end
		end else begin
			state_q <= state_d;
			if (fire) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_DEC: begin
					priority if (cmd_q == CMD_NOTIFY) begin
						if (!p_bad && can_emit) begin
							if (recv_q[p_idx]) recv_q[p_idx] <= 1'b0;
							else pend_q[p_idx] <= 1'b1;
						end
					end else if (is_reject) begin
					end else if (cmd_q == CMD_RECV) begin
						if (pend_q[c_idx]) begin
							if (can_emit) pend_q[c_idx] <= 1'b0;
						end
					end else if (direct_ok) begin
						if (can_emit) recv_q[p_idx] <= 1'b0;
					end else begin
						send_q[c_idx] <= 1'b1;
						if (cmd_q == CMD_SENDREC) recv_q[c_idx] <= 1'b1;
						if (hd == NO_PROC) head_q[p_idx] <= LW'(c_q);
					end
				end
				ST_BLK_R: begin
					if (can_emit) recv_q[c_idx] <= 1'b1;
				end
				ST_T_CHK: begin
					if (match && prev_q == NO_PROC) head_q[c_idx] <= nx_rdata;
				end
				ST_T_REL: begin
					if (can_emit) send_q[ptr_idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (fire) od_q <= res_d;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cmd_q <= cmd_t'(req.cmd);
					c_q <= req.caller;
					peer_q <= req.peer;
					type_q <= req.msg_type;
					pay_q <= req.msg_payload;
				end
			end
			ST_DEC: begin
				ptr_q <= hd;
				prev_q <= NO_PROC;
				want_q <= LW'(peer_q);
				if (cmd_q != CMD_NOTIFY && !is_reject && cmd_q != CMD_RECV && !direct_ok
						&& cmd_q == CMD_SENDREC) begin
					ws_q[c_idx] <= LW'(peer_q);
				end
			end
			ST_A_CHK: begin
				if (nx_rdata != NO_PROC) ptr_q <= nx_rdata;
			end
			ST_T_CHK: begin
				if (!match && nx_rdata != NO_PROC) begin
					prev_q <= ptr_q;
					ptr_q <= nx_rdata;
				end
			end
			ST_BLK_R: ws_q[c_idx] <= want_q;
			default: ;
		endcase
	end

	assign res.valid = ov_q;
	assign res.target = od_q.target;
	assign res.kind = od_q.kind;
	assign res.msg_from = od_q.msg_from;
	assign res.msg_out_type = od_q.msg_out_type;
	assign res.msg_out_payload = od_q.msg_out_payload;
	assign res.runnable = od_q.runnable;
	assign res.last = od_q.last;
endmodule

[sv/rmie_chk.sv]
// Port-level checks of the rendezvous message engine result channel.
module rmie_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  kind,
	input logic [4:0]  msg_from,
	input logic [7:0]  msg_out_type,
	input logic [63:0] msg_out_payload,
	input logic        runnable,
	input logic        last
);
	import rmie_pkg::*;

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (kind == KIND_DONE || kind == KIND_REJECT || kind == KIND_BLOCKED
			|| kind == KIND_DELIVER || kind == KIND_RELEASED))
		else $error("result kind out of range");

	a_no_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind != KIND_DELIVER) |->
			(msg_from == 5'd0 && msg_out_type == 8'd0 && msg_out_payload == 64'd0))
		else $error("message fields set on a non-delivery result");

	a_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_BLOCKED) |-> (!runnable && last))
		else $error("blocked result runnable or not last");

	a_release_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && kind == KIND_RELEASED) |-> last)
		else $error("sender release is not the final result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !ready) |=> (valid && $stable(kind) && $stable(last)))
		else $error("stalled result changed");
endmodule

bind rendezvous_message_ipc_engine rmie_chk u_rmie_chk (
	.clk(clk),
	.arst_n(arst_n),
	.valid(res.valid),
	.ready(res.ready),
	.kind(res.kind),
	.msg_from(res.msg_from),
	.msg_out_type(res.msg_out_type),
	.msg_out_payload(res.msg_out_payload),
	.runnable(res.runnable),
	.last(res.last)
);

[verif/tb_rendezvous_message_ipc_engine.sv]
// Testbench of the rendezvous message engine: random and directed requests against a predictor.
`timescale 1ns / 1ps

import rmie_pkg::*;

class ipc_scoreboard;
	localparam int NP = PROC_COUNT_DEF;
	localparam logic [4:0] NONE = 5'(NP);

	bit          snd_flag [NP];
	bit          rcv_flag [NP];
	bit          ntf_pend [NP];
	logic [4:0]  wait_src [NP];
	logic [7:0]  hold_type [NP];
	logic [63:0] hold_pay [NP];
	logic [4:0]  q_head [NP];
	logic [4:0]  q_next [NP];
	res_t        pending_res [$];
	res_t        cur [$];
	int          errors;
	int          n_req;
	int          n_res;
	int          n_deliver;

	function new();
		for (int i = 0; i < NP; i++) begin
			snd_flag[i] = 0;
			rcv_flag[i] = 0;
			ntf_pend[i] = 0;
			q_head[i] = NONE;
			q_next[i] = NONE;
		end
		errors = 0;
		n_req = 0;
		n_res = 0;
		n_deliver = 0;
	endfunction

	function bit is_free(int p);
		return !snd_flag[p] && !rcv_flag[p];
	endfunction

	function void add(int tgt, kind_t k, logic [4:0] from, logic [7:0] typ,
		logic [63:0] pay, bit run);
		res_t r;
		r.target = 4'(tgt);
		r.kind = k;
		r.msg_from = from;
		r.msg_out_type = typ;
		r.msg_out_payload = pay;
		r.runnable = run;
		r.last = 0;
		cur.push_back(r);
	endfunction

	function void append_sender(int d, int c);
		logic [4:0] t;
		q_next[c] = NONE;
		if (q_head[d] == NONE) begin
			q_head[d] = 5'(c);
			return;
		end
		t = q_head[d];
		while (q_next[t] != NONE) t = q_next[t];
		q_next[t] = 5'(c);
	endfunction

	// Unlink the first queued sender of c that matches want.
	function logic [4:0] take_sender(int c, logic [4:0] want);
		logic [4:0] prev, s;
		prev = NONE;
		s = q_head[c];
		while (s != NONE) begin
			if (want == NONE || want == s) begin
				if (prev == NONE) q_head[c] = q_next[s];
				else q_next[prev] = q_next[s];
				q_next[s] = NONE;
				return s;
			end
			prev = s;
			s = q_next[s];
		end
		return NONE;
	endfunction

	function void take_from(int c, int s);
		add(c, KIND_DELIVER, 5'(s), hold_type[s], hold_pay[s], is_free(c));
		snd_flag[s] = 0;
		add(s, KIND_RELEASED, 0, 0, 0, is_free(s));
	endfunction

	function bit direct_send(int c, int d, logic [7:0] typ, logic [63:0] pay);
		if (!rcv_flag[d]) return 0;
		if (wait_src[d] != NONE && wait_src[d] != c) return 0;
		rcv_flag[d] = 0;
		add(d, KIND_DELIVER, 5'(c), typ, pay, is_free(d));
		return 1;
	endfunction

	function void hold_and_queue(int c, int d, logic [7:0] typ, logic [63:0] pay);
		snd_flag[c] = 1;
		hold_type[c] = typ;
		hold_pay[c] = pay;
		append_sender(d, c);
	endfunction

	function void receive_from(int c, logic [4:0] src);
		logic [4:0] s;
		s = take_sender(c, src);
		if (s != NONE) take_from(c, s);
		else begin
			rcv_flag[c] = 1;
			wait_src[c] = src;
			add(c, KIND_BLOCKED, 0, 0, 0, 0);
		end
	endfunction

	function void note_request(cmd_t cmd, logic [3:0] c, logic [4:0] peer,
		logic [7:0] typ, logic [63:0] pay);
		cur.delete();
		n_req++;
		if (cmd == CMD_NOTIFY) begin
			if (peer >= NP) add(0, KIND_REJECT, 0, 0, 0, 0);
			else if (rcv_flag[peer]) begin
				rcv_flag[peer] = 0;
				add(peer, KIND_DELIVER, NONE, NOTIFY_TYPE, NOTIFY_PAYLOAD, is_free(peer));
			end else begin
				ntf_pend[peer] = 1;
				add(peer, KIND_DONE, 0, 0, 0, is_free(peer));
			end
		end else if (!is_free(c)) add(c, KIND_REJECT, 0, 0, 0, 0);
		else if (cmd == CMD_RECV ? peer > NP : peer >= NP) add(c, KIND_REJECT, 0, 0, 0, 1);
		else if (cmd == CMD_SEND) begin
			if (direct_send(c, peer, typ, pay)) add(c, KIND_DONE, 0, 0, 0, is_free(c));
			else begin
				hold_and_queue(c, peer, typ, pay);
				add(c, KIND_BLOCKED, 0, 0, 0, 0);
			end
		end else if (cmd == CMD_RECV) begin
			if (ntf_pend[c]) begin
				ntf_pend[c] = 0;
				add(c, KIND_DELIVER, NONE, NOTIFY_TYPE, NOTIFY_PAYLOAD, 1);
			end else receive_from(c, peer);
		end else begin
			if (direct_send(c, peer, typ, pay)) receive_from(c, peer);
			else begin
				hold_and_queue(c, peer, typ, pay);
				rcv_flag[c] = 1;
				wait_src[c] = peer;
				add(c, KIND_BLOCKED, 0, 0, 0, 0);
			end
		end
		cur[cur.size() - 1].last = 1;
		foreach (cur[i]) pending_res.push_back(cur[i]);
	endfunction

	function void check_result(res_t got);
		res_t e;
		n_res++;
		if (pending_res.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		e = pending_res.pop_front();
		if (got.kind == KIND_DELIVER) n_deliver++;
		if (got.target !== e.target)
			$display("%0t: target exp %0d got %0d", $time, e.target, got.target);
		if (got.kind !== e.kind)
			$display("%0t: kind exp %0d got %0d", $time, e.kind, got.kind);
		if (got.msg_from !== e.msg_from)
			$display("%0t: msg_from exp %0d got %0d", $time, e.msg_from, got.msg_from);
		if (got.msg_out_type !== e.msg_out_type)
			$display("%0t: msg_out_type exp %0h got %0h", $time, e.msg_out_type,
				got.msg_out_type);
		if (got.msg_out_payload !== e.msg_out_payload)
			$display("%0t: msg_out_payload exp %0h got %0h", $time, e.msg_out_payload,
				got.msg_out_payload);
		if (got.runnable !== e.runnable)
			$display("%0t: runnable exp %0b got %0b", $time, e.runnable, got.runnable);
		if (got.last !== e.last)
			$display("%0t: last exp %0b got %0b", $time, e.last, got.last);
		if (got !== e) errors++;
	endfunction
endclass

module tb_rendezvous_message_ipc_engine;
	localparam int LIMIT = 300000;
	localparam int N_RANDOM = 170;

	logic clk;
	logic arst_n;
	int   cycles;
	bit   stall_mode;
	ipc_scoreboard sb;

	rmie_req_if req_ch();
	rmie_res_if res_ch();

	rendezvous_message_ipc_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Note accepted requests before checking results of the same edge.
	always @(posedge clk) begin
		res_t got;
		if (req_ch.valid && req_ch.ready)
			sb.note_request(cmd_t'(req_ch.cmd), req_ch.caller, req_ch.peer,
				req_ch.msg_type, req_ch.msg_payload);
		if (res_ch.valid && res_ch.ready) begin
			got.target = res_ch.target;
			got.kind = res_ch.kind;
			got.msg_from = res_ch.msg_from;
			got.msg_out_type = res_ch.msg_out_type;
			got.msg_out_payload = res_ch.msg_out_payload;
			got.runnable = res_ch.runnable;
			got.last = res_ch.last;
			sb.check_result(got);
		end
	end

	// Receiver: switch between a free-running and a stalling pattern.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
		res_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Drive one request and hold it until accepted.
	task automatic issue(cmd_t cmd, int c, int peer, logic [7:0] typ, logic [63:0] pay);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.caller <= 4'(c);
		req_ch.peer <= 5'(peer);
		req_ch.msg_type <= typ;
		req_ch.msg_payload <= pay;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic idle(int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait for the next edge first so the request accepted at this edge is already noted.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_res.size() != 0);
	endtask

	function automatic int pick_caller();
		int c;
		c = $urandom_range(0, 15);
		if ($urandom_range(0, 3) != 0)
			for (int i = 0; i < 16; i++)
				if (sb.is_free((c + i) % 16)) return (c + i) % 16;
		return c;
	endfunction

	function automatic int pick_peer(cmd_t cmd);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom_range(17, 31);
		if (r == 1 || (r < 4 && cmd == CMD_RECV)) return 16;
		return $urandom_range(0, 15);
	endfunction

	initial begin
		int burst;
		cmd_t cmd;
		sb = new();
		clk = 1'b0;
		cycles = 0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_SEND;
		req_ch.caller = '0;
		req_ch.peer = '0;
		req_ch.msg_type = '0;
		req_ch.msg_payload = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, bad peers, busy callers, pending notify, self send.
		issue(CMD_SEND, 0, 1, 8'h00, 64'h0);
		issue(CMD_SEND, 2, 1, 8'hFF, '1);
		issue(CMD_SEND, 0, 3, 8'h11, 64'h1);
		issue(CMD_RECV, 1, 2, 8'h00, 64'h0);
		issue(CMD_RECV, 1, 16, 8'h00, 64'h0);
		issue(CMD_SEND, 4, 16, 8'h12, 64'h5);
		issue(CMD_RECV, 4, 31, 8'h12, 64'h5);
		issue(CMD_NOTIFY, 0, 31, 8'h00, 64'h0);
		issue(CMD_NOTIFY, 0, 5, 8'h00, 64'h0);
		issue(CMD_NOTIFY, 0, 5, 8'h00, 64'h0);
		issue(CMD_RECV, 5, 16, 8'h00, 64'h0);
		issue(CMD_RECV, 5, 7, 8'h00, 64'h0);
		issue(CMD_NOTIFY, 0, 5, 8'h00, 64'h0);
		issue(CMD_RECV, 6, 15, 8'h00, 64'h0);
		issue(CMD_SENDREC, 15, 6, 8'hA5, 64'hDEAD_BEEF_0123_4567);
		issue(CMD_SEND, 6, 15, 8'h5A, 64'h8000_0000_0000_0000);
		issue(CMD_SENDREC, 8, 9, 8'h77, 64'h7);
		issue(CMD_SEND, 8, 9, 8'h77, 64'h7);
		issue(CMD_SEND, 10, 10, 8'h01, 64'h10);
		issue(CMD_RECV, 10, 10, 8'h00, 64'h0);
		issue(CMD_SEND, 11, 12, 8'h03, 64'h3);
		issue(CMD_RECV, 12, 16, 8'h00, 64'h0);
		issue(CMD_SENDREC, 3, 0, 8'hFE, 64'hFFFF_0000_FFFF_0000);
		drain();

		for (int n = 0; n < N_RANDOM; n += burst) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				cmd = cmd_t'($urandom_range(0, 3));
				issue(cmd, pick_caller(), pick_peer(cmd), 8'($urandom),
					{$urandom, $urandom});
			end
			if (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 13) drain();
			else if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 30));
		end

		drain();
		repeat (80) @(posedge clk);
		$display("Run covered %0d requests and %0d results, %0d of them deliveries.",
			sb.n_req, sb.n_res, sb.n_deliver);
		if (sb.errors == 0 && sb.pending_res.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
